// ----- rtl/core/freq_domain_inverse_swt_macros.svh -----
// ----------------------------------------------------------------------------
// freq_domain_inverse_swt_macros.svh
// Assertion macros used by the checker of the inverse SWT block.
// ----------------------------------------------------------------------------
`ifndef FREQ_DOMAIN_INVERSE_SWT_MACROS_SVH
`define FREQ_DOMAIN_INVERSE_SWT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define FDIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define FDIS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define FDIS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/fdis_pkg.sv -----
// ----------------------------------------------------------------------------
// fdis_pkg
// Types, constants and arithmetic helpers of the inverse SWT block.
// ----------------------------------------------------------------------------
package fdis_pkg;

  localparam int MaxLen       = 1024;
  localparam int MaxLevelsDef = 8;
  localparam int DataW        = 24;
  localparam int CoefW        = 18;
  localparam int IdxW         = $clog2(MaxLen);
  localparam int LenW         = 11;
  localparam int LvlW         = 4;
  localparam int ApbAddrW     = 3;
  localparam int ApbDataW     = 32;
  localparam int StepsPerStage = 6;

  localparam int RoundShift = 16;
  localparam int RoundHalf  = 2 ** (RoundShift - 1);
  localparam int ProdW      = DataW + CoefW + 1;
  localparam int RndW       = ProdW + 1;
  localparam int ShW        = RndW - RoundShift;
  localparam int SumW       = ShW + 1;

  localparam logic [LenW-1:0] SigLenRst = LenW'(MaxLen);
  localparam logic [LenW-1:0] SigLenMin = LenW'(2);
  localparam logic [LvlW-1:0] LevelsRst = LvlW'(1);

  // Register select bit of the APB address.
  localparam logic RegSigLen = 1'b0;
  localparam logic RegLevels = 1'b1;

  typedef enum logic [1:0] {
    ReqLoad   = 2'd0,
    ReqApprox = 2'd1,
    ReqDetail = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    KindLoad,
    KindApprox,
    KindDetail
  } item_kind_e;

  typedef struct packed {
    item_kind_e              kind;
    logic                    emit;
    logic                    col;
    logic [IdxW-1:0]         idx;
    logic [LvlW-1:0]         k;
    logic [LenW-1:0]         n;
    logic [IdxW-1:0]         rem;
    logic signed [DataW-1:0] re;
    logic signed [DataW-1:0] im;
  } item_t;

  function automatic logic [CoefW-1:0] sat_coef(input logic signed [DataW-1:0] v);
    if ((&v[DataW-1:CoefW-1]) || !(|v[DataW-1:CoefW-1])) begin
      return v[CoefW-1:0];
    end
    return {v[DataW-1], {(CoefW-1){~v[DataW-1]}}};
  endfunction

  function automatic logic [DataW-1:0] sat_data(input logic signed [SumW-1:0] v);
    if ((&v[SumW-1:DataW-1]) || !(|v[SumW-1:DataW-1])) begin
      return v[DataW-1:0];
    end
    return {v[SumW-1], {(DataW-1){~v[SumW-1]}}};
  endfunction

  // Rounds (a1*h1 -/+ a2*h2) / 2^16 half up.
  function automatic logic signed [ShW-1:0] prod_round(
    input logic signed [DataW-1:0] a1,
    input logic signed [CoefW-1:0] h1,
    input logic signed [DataW-1:0] a2,
    input logic signed [CoefW-1:0] h2,
    input logic                    neg
  );
    logic signed [DataW+CoefW-1:0] m1;
    logic signed [DataW+CoefW-1:0] m2;
    logic signed [ProdW-1:0]       s;
    logic [RndW-1:0]               t;
    m1 = a1 * h1;
    m2 = a2 * h2;
    s  = neg ? (ProdW'(m1) - ProdW'(m2)) : (ProdW'(m1) + ProdW'(m2));
    t  = {s[ProdW-1], s} + RndW'(RoundHalf);
    return t[RndW-1:RoundShift];
  endfunction

endpackage

// ----- rtl/core/freq_domain_inverse_swt.sv -----
// ----------------------------------------------------------------------------
// freq_domain_inverse_swt
// Frequency-domain inverse stationary wavelet transform, one bin at a time.
// ----------------------------------------------------------------------------
// The block takes one transfer per clock cycle, unless a stalled output holds
// the pipeline, for filter loads, approximations and details alike. Every item
// runs through a fixed pipeline: ceil((9 + MAX_LEVELS) / 6) stages that build
// the filter index by double-and-subtract (three at the default), one filter
// store access, one stage for the detail product and one accumulate stage,
// which also loads the output register. The accumulate stage is a complex
// multiply-add in combinational logic into the accumulator, which is what lets
// details of one bin follow each other without gaps. A stalled output holds an
// item that finishes a bin in the accumulate stage, and the items behind it
// wait in the stages before it; items that finish no bin pass the accumulate
// stage while the output waits.
// ----------------------------------------------------------------------------
module freq_domain_inverse_swt #(
  parameter int MAX_LEVELS = fdis_pkg::MaxLevelsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fdis_pkg::ApbAddrW-1:0]       paddr,
  input  logic [fdis_pkg::ApbDataW-1:0]       pwdata,
  output logic [fdis_pkg::ApbDataW-1:0]       prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          req_type_i,
  input  logic [fdis_pkg::IdxW-1:0]           index_i,
  input  logic                                filter_col_i,
  input  logic signed [fdis_pkg::DataW-1:0]   value_re_i,
  input  logic signed [fdis_pkg::DataW-1:0]   value_im_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [fdis_pkg::IdxW-1:0]           bin_o,
  output logic signed [fdis_pkg::DataW-1:0]   out_re_o,
  output logic signed [fdis_pkg::DataW-1:0]   out_im_o
);
  import fdis_pkg::*;

  localparam int Steps     = IdxW + MAX_LEVELS - 1;
  localparam int NumRemStg = (Steps + StepsPerStage - 1) / StepsPerStage;
  localparam logic [LvlW:0] LvlCap = (LvlW + 1)'(MAX_LEVELS);

  // Configuration registers.
  logic [LenW-1:0] sig_len_q;
  logic [LvlW-1:0] levels_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == RegLevels) ? ApbDataW'(levels_q) : ApbDataW'(sig_len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_len_q <= SigLenRst;
      levels_q  <= LevelsRst;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegSigLen: sig_len_q <= pwdata[LenW-1:0];
        RegLevels: levels_q  <= pwdata[LvlW-1:0];
        default: ;
      endcase
    end
  end

  // Front end: bin tracking and item decode.
  logic [IdxW-1:0] cur_bin_q, cur_bin_d;
  logic [LvlW-1:0] lvl_left_q, lvl_left_d;
  item_t           front_item;
  logic            front_vld;
  logic            in_xfer;
  logic [LvlW-1:0] lvl_start;
  logic [LenW-1:0] len_eff;

  logic [NumRemStg:0]   free_chain;
  logic [NumRemStg-1:0] rem_vld_q;
  item_t                rem_item_q [NumRemStg];

  assign in_ready_o = free_chain[0];
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    lvl_start = ({1'b0, levels_q} > LvlCap) ? LvlCap[LvlW-1:0] : levels_q;
    if (sig_len_q < SigLenMin) begin
      len_eff = SigLenMin;
    end else if (sig_len_q > SigLenRst) begin
      len_eff = SigLenRst;
    end else begin
      len_eff = sig_len_q;
    end

    front_item      = '0;
    front_item.kind = KindLoad;
    front_item.col  = filter_col_i;
    front_item.idx  = index_i;
    front_item.n    = len_eff;
    front_item.re   = value_re_i;
    front_item.im   = value_im_i;
    front_vld       = 1'b0;
    cur_bin_d       = cur_bin_q;
    lvl_left_d      = lvl_left_q;

    unique case (req_type_e'(req_type_i))
      ReqLoad: begin
        front_vld = in_xfer;
      end
      ReqApprox: begin
        front_item.kind = KindApprox;
        front_item.emit = (lvl_start == '0);
        front_vld       = in_xfer;
        cur_bin_d       = index_i;
        lvl_left_d      = lvl_start;
      end
      ReqDetail: begin
        if (lvl_left_q != '0) begin
          front_item.kind = KindDetail;
          front_item.idx  = cur_bin_q;
          front_item.k    = lvl_left_q - LvlW'(1);
          front_item.emit = (lvl_left_q == LvlW'(1));
          front_vld       = in_xfer;
          lvl_left_d      = lvl_left_q - LvlW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_bin_q  <= '0;
      lvl_left_q <= '0;
    end else if (in_xfer) begin
      cur_bin_q  <= cur_bin_d;
      lvl_left_q <= lvl_left_d;
    end
  end

  // Filter index: (bin * 2^k) mod n, one restoring step per bin bit and per level.
  for (genvar gs = 0; gs < NumRemStg; gs++) begin : g_rem
    item_t src;
    item_t nxt;
    logic  src_vld;

    if (gs == 0) begin : g_first
      assign src     = front_item;
      assign src_vld = front_vld;
    end else begin : g_next
      assign src     = rem_item_q[gs-1];
      assign src_vld = rem_vld_q[gs-1];
    end

    always_comb begin : p_step
      logic [IdxW:0] t;
      logic          b;
      logic          act;
      int            j;
      nxt = src;
      for (int i = 0; i < StepsPerStage; i++) begin
        j = gs * StepsPerStage + i;
        if (j < IdxW) begin
          b   = src.idx[IdxW-1-j];
          act = 1'b1;
        end else begin
          b   = 1'b0;
          act = (j < Steps) && ((j - IdxW) < int'(src.k));
        end
        t = {nxt.rem, b};
        if (act) begin
          if (t >= nxt.n) begin
            t = t - nxt.n;
          end
          nxt.rem = t[IdxW-1:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rem_vld_q[gs] <= 1'b0;
      end else if (free_chain[gs]) begin
        rem_vld_q[gs] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (free_chain[gs]) begin
        rem_item_q[gs] <= nxt;
      end
    end
  end

  // Filter store access.
  item_t              last_item;
  logic               last_vld;
  logic [2*CoefW-1:0] scl_mem_q [MaxLen];
  logic [2*CoefW-1:0] wvl_mem_q [MaxLen];
  logic [2*CoefW-1:0] scl_rd_q;
  logic [2*CoefW-1:0] wvl_rd_q;
  logic [2*CoefW-1:0] coef_wr;
  logic               load_wr;
  logic               mem_free;
  logic               mem_vld_q;
  item_t              mem_item_q;

  assign last_item = rem_item_q[NumRemStg-1];
  assign last_vld  = rem_vld_q[NumRemStg-1];
  assign coef_wr   = {sat_coef(last_item.re), sat_coef(last_item.im)};
  assign load_wr   = mem_free && last_vld && (last_item.kind == KindLoad);

  always_ff @(posedge clk_i) begin
    if (load_wr && !last_item.col) begin
      scl_mem_q[last_item.idx] <= coef_wr;
    end
    if (mem_free) begin
      scl_rd_q <= scl_mem_q[last_item.rem];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_wr && last_item.col) begin
      wvl_mem_q[last_item.idx] <= coef_wr;
    end
    if (mem_free) begin
      wvl_rd_q <= wvl_mem_q[last_item.rem];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_vld_q <= 1'b0;
    end else if (mem_free) begin
      mem_vld_q <= last_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_free) begin
      mem_item_q <= last_item;
    end
  end

  // Detail product d * Hw.
  logic signed [CoefW-1:0] hw_re, hw_im;
  logic                    a_free;
  logic                    a_vld_q;
  item_t                   a_item_q;
  logic signed [ShW-1:0]   q_re_q, q_im_q;
  logic [2*CoefW-1:0]      a_hs_q;

  assign hw_re = wvl_rd_q[2*CoefW-1:CoefW];
  assign hw_im = wvl_rd_q[CoefW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (a_free) begin
      a_vld_q <= mem_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_free) begin
      a_item_q <= mem_item_q;
      a_hs_q   <= scl_rd_q;
      q_re_q   <= prod_round(mem_item_q.re, hw_re, mem_item_q.im, hw_im, 1'b1);
      q_im_q   <= prod_round(mem_item_q.re, hw_im, mem_item_q.im, hw_re, 1'b0);
    end
  end

  // Accumulate and result register.
  logic signed [CoefW-1:0] hs_re, hs_im;
  logic signed [DataW-1:0] acc_re_q, acc_im_q, acc_re_d, acc_im_d;
  logic signed [ShW-1:0]   p_re, p_im;
  logic signed [SumW-1:0]  sum_re, sum_im;
  logic                    a_en_l;
  logic                    out_vld_q;
  logic [IdxW-1:0]         bin_q;
  logic signed [DataW-1:0] out_re_q, out_im_q;

  assign hs_re  = a_hs_q[2*CoefW-1:CoefW];
  assign hs_im  = a_hs_q[CoefW-1:0];
  assign a_en_l = a_vld_q && (!a_item_q.emit || !out_vld_q || out_ready_i);
  assign a_free = !a_vld_q || a_en_l;
  assign mem_free = !mem_vld_q || a_free;

  always_comb begin
    free_chain[NumRemStg] = mem_free;
    for (int s = NumRemStg - 1; s >= 0; s--) begin
      free_chain[s] = !rem_vld_q[s] || free_chain[s+1];
    end
  end

  always_comb begin
    p_re     = prod_round(acc_re_q, hs_re, acc_im_q, hs_im, 1'b1);
    p_im     = prod_round(acc_re_q, hs_im, acc_im_q, hs_re, 1'b0);
    sum_re   = SumW'(p_re) + SumW'(q_re_q);
    sum_im   = SumW'(p_im) + SumW'(q_im_q);
    acc_re_d = acc_re_q;
    acc_im_d = acc_im_q;
    unique case (a_item_q.kind)
      KindApprox: begin
        acc_re_d = a_item_q.re;
        acc_im_d = a_item_q.im;
      end
      KindDetail: begin
        acc_re_d = sat_data(sum_re);
        acc_im_d = sat_data(sum_im);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_re_q  <= '0;
      acc_im_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (a_en_l) begin
        acc_re_q <= acc_re_d;
        acc_im_q <= acc_im_d;
      end
      if (a_en_l && a_item_q.emit) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_en_l && a_item_q.emit) begin
      bin_q    <= a_item_q.idx;
      out_re_q <= acc_re_d;
      out_im_q <= acc_im_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign bin_o       = bin_q;
  assign out_re_o    = out_re_q;
  assign out_im_o    = out_im_q;

endmodule

// ----- rtl/core/fdis_checker.sv -----
// ----------------------------------------------------------------------------
// fdis_checker
// Port-level assertions for the inverse SWT block, bound to its top level.
// ----------------------------------------------------------------------------
`include "freq_domain_inverse_swt_macros.svh"

module fdis_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                psel,
  input logic                                penable,
  input logic                                pwrite,
  input logic [fdis_pkg::ApbAddrW-1:0]       paddr,
  input logic [fdis_pkg::ApbDataW-1:0]       pwdata,
  input logic [fdis_pkg::ApbDataW-1:0]       prdata,
  input logic                                pready,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [fdis_pkg::IdxW-1:0]           bin_o,
  input logic signed [fdis_pkg::DataW-1:0]   out_re_o,
  input logic signed [fdis_pkg::DataW-1:0]   out_im_o
);
  import fdis_pkg::*;

  `FDIS_ASSERT(a_pready_high, pready, "APB pready dropped")

  `FDIS_ASSERT_IMP(a_in_ready_free, (!out_valid_o || out_ready_i), in_ready_o, "input stalled with free output")

  `FDIS_ASSERT_NXT(a_out_hold, (out_valid_o && !out_ready_i), (out_valid_o && $stable(bin_o) && $stable(out_re_o) && $stable(out_im_o)), "stalled result transfer changed")

  `FDIS_ASSERT_NXT(a_len_readback, (psel && penable && pwrite && (paddr[2] == RegSigLen)), ((paddr[2] != RegSigLen) || (prdata[LenW-1:0] == $past(pwdata[LenW-1:0]))), "sig_len readback mismatch")

endmodule

bind freq_domain_inverse_swt fdis_checker u_fdis_checker (.*);

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the frequency-domain inverse SWT block.
// ----------------------------------------------------------------------------
// An initial block builds the input transfers, predicts every reconstructed
// bin from its own copy of the filter store and the registers, and walks
// through several register settings. A clocked driver feeds the transfers
// with random gaps, a clocked receiver stalls the output at random, and a
// clocked monitor compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import fdis_pkg::*;

  localparam logic [1:0] ReqUnused = 2'd3;
  localparam int HalfLsb = 32768;
  localparam int FracShift = 16;
  localparam int DrainCycles = 32;
  localparam int LongHold = 400;
  localparam int WatchdogLimit = 4000;
  localparam int PhaseItems = 150;
  localparam logic signed [DataW-1:0] DataMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] DataMin = {1'b1, {(DataW-1){1'b0}}};

  typedef struct packed {
    logic [1:0]              req;
    logic [IdxW-1:0]         idx;
    logic                    col;
    logic signed [DataW-1:0] re;
    logic signed [DataW-1:0] im;
  } swt_item_t;

  typedef struct packed {
    logic [IdxW-1:0]         bin;
    logic signed [DataW-1:0] re;
    logic signed [DataW-1:0] im;
  } swt_out_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [ApbAddrW-1:0]       paddr = '0;
  logic [ApbDataW-1:0]       pwdata = '0;
  logic [ApbDataW-1:0]       prdata;
  logic                      pready;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [1:0]                req_type_i = '0;
  logic [IdxW-1:0]           index_i = '0;
  logic                      filter_col_i = 1'b0;
  logic signed [DataW-1:0]   value_re_i = '0;
  logic signed [DataW-1:0]   value_im_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [IdxW-1:0]           bin_o;
  logic signed [DataW-1:0]   out_re_o;
  logic signed [DataW-1:0]   out_im_o;

  freq_domain_inverse_swt dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .index_i      (index_i),
    .filter_col_i (filter_col_i),
    .value_re_i   (value_re_i),
    .value_im_i   (value_im_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .bin_o        (bin_o),
    .out_re_o     (out_re_o),
    .out_im_o     (out_im_o)
  );

  swt_item_t swt_pending[$];
  swt_out_t  recon_expected[$];

  longint coef_re [2*MaxLen];
  longint coef_im [2*MaxLen];
  bit     coef_loaded [2*MaxLen];
  longint rec_acc_re = 0;
  longint rec_acc_im = 0;
  logic [IdxW-1:0] rec_bin = '0;
  int     rec_left = 0;
  int     cfg_sig_len = MaxLen;
  int     cfg_levels = 1;

  int  n_counted = 0;
  int  n_settings = 0;
  int  items_accepted = 0;
  int  results_checked = 0;
  int  recon_errors = 0;
  int  hold_requests = 0;
  int  hold_served = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  hold_cnt = 0;
  int  stall_cycles = 0;
  bit  send_idle_en = 1'b1;
  bit  recv_idle_en = 1'b1;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint sat_w(input longint v, input int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint round_q16(input longint x);
    return (x + HalfLsb) >>> FracShift;
  endfunction

  function automatic int eff_len();
    if (cfg_sig_len < 2) return 2;
    if (cfg_sig_len > MaxLen) return MaxLen;
    return cfg_sig_len;
  endfunction

  function automatic int filt_pos(input int b, input int k, input int n);
    int x;
    x = b % n;
    repeat (k) begin
      x = 2 * x;
      if (x >= n) x = x - n;
    end
    return x;
  endfunction

  function automatic void emit_bin();
    swt_out_t r;
    r.bin = rec_bin;
    r.re  = DataW'(sat_w(rec_acc_re, DataW));
    r.im  = DataW'(sat_w(rec_acc_im, DataW));
    recon_expected.push_back(r);
  endfunction

  function automatic void recon_predict(input swt_item_t it);
    int a;
    int fi;
    longint dre;
    longint dim;
    longint pre;
    longint pim;
    longint qre;
    longint qim;
    case (it.req)
      ReqLoad: begin
        a = int'(it.col) * MaxLen + int'(it.idx);
        coef_re[a] = sat_w(longint'(it.re), CoefW);
        coef_im[a] = sat_w(longint'(it.im), CoefW);
        coef_loaded[a] = 1'b1;
      end
      ReqApprox: begin
        rec_acc_re = sat_w(longint'(it.re), DataW);
        rec_acc_im = sat_w(longint'(it.im), DataW);
        rec_bin = it.idx;
        rec_left = (cfg_levels > MaxLevelsDef) ? MaxLevelsDef : cfg_levels;
        if (rec_left == 0) emit_bin();
      end
      ReqDetail: begin
        if (rec_left != 0) begin
          fi = filt_pos(int'(rec_bin), rec_left - 1, eff_len());
          dre = sat_w(longint'(it.re), DataW);
          dim = sat_w(longint'(it.im), DataW);
          pre = round_q16(rec_acc_re * coef_re[fi] - rec_acc_im * coef_im[fi]);
          pim = round_q16(rec_acc_re * coef_im[fi] + rec_acc_im * coef_re[fi]);
          qre = round_q16(dre * coef_re[MaxLen+fi] - dim * coef_im[MaxLen+fi]);
          qim = round_q16(dre * coef_im[MaxLen+fi] + dim * coef_re[MaxLen+fi]);
          rec_acc_re = sat_w(pre + qre, DataW);
          rec_acc_im = sat_w(pim + qim, DataW);
          rec_left = rec_left - 1;
          if (rec_left == 0) emit_bin();
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void push_item(input logic [1:0] req, input logic [IdxW-1:0] idx,
                                    input logic col, input logic signed [DataW-1:0] re,
                                    input logic signed [DataW-1:0] im);
    swt_item_t it;
    it = '{req: req, idx: idx, col: col, re: re, im: im};
    if (req != ReqUnused && !(req == ReqDetail && rec_left == 0)) n_counted++;
    swt_pending.push_back(it);
    recon_predict(it);
  endfunction

  function automatic logic signed [DataW-1:0] rand_data();
    case ($urandom_range(0, 9))
      0: return DataMax;
      1: return DataMin;
      2, 3: return DataW'($signed(20'($urandom)));
      default: return DataW'($urandom);
    endcase
  endfunction

  function automatic logic signed [DataW-1:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return DataMax;
      1: return DataMin;
      2: return DataW'($urandom);
      3, 4, 5: return DataW'($signed(18'($urandom)));
      default: return DataW'($signed(16'($urandom)));
    endcase
  endfunction

  function automatic void push_load(input logic col, input logic [IdxW-1:0] idx);
    push_item(ReqLoad, idx, col, rand_coef(), rand_coef());
  endfunction

  // A detail must never read a filter entry that was never loaded.
  function automatic void push_detail(input logic signed [DataW-1:0] re,
                                      input logic signed [DataW-1:0] im);
    int fi;
    if (rec_left != 0) begin
      fi = filt_pos(int'(rec_bin), rec_left - 1, eff_len());
      if (!coef_loaded[fi]) push_load(1'b0, IdxW'(fi));
      if (!coef_loaded[MaxLen+fi]) push_load(1'b1, IdxW'(fi));
    end
    push_item(ReqDetail, IdxW'($urandom), 1'($urandom), re, im);
  endfunction

  function automatic void push_bin(input bit broken);
    int cut;
    push_item(ReqApprox, IdxW'($urandom), 1'($urandom), rand_data(), rand_data());
    cut = rec_left;
    if (broken && rec_left != 0) cut = $urandom_range(0, rec_left - 1);
    repeat (cut) push_detail(rand_data(), rand_data());
  endfunction

  function automatic void run_phase(input int quota);
    int start;
    int r;
    start = n_counted;
    while (n_counted - start < quota) begin
      r = $urandom_range(0, 99);
      if (r < 80) push_bin(1'b0);
      else if (r < 86) push_bin(1'b1);
      else if (r < 91) push_detail(rand_data(), rand_data());
      else if (r < 95) push_item(ReqUnused, IdxW'($urandom), 1'($urandom),
                                 rand_data(), rand_data());
      else push_load(1'($urandom), IdxW'($urandom));
    end
  endfunction

  task automatic apb_write(input logic sel, input int value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= ApbDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input int len, input int lv);
    apb_write(RegSigLen, len);
    apb_write(RegLevels, lv);
    cfg_sig_len = len & 'h7FF;
    cfg_levels  = lv & 'hF;
    n_settings++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    while (swt_pending.size() != 0 || in_valid_i || recon_expected.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  initial begin
    int len;
    int lv;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset settings first, then extremes of the filter and data fields.
    push_bin(1'b0);
    wait_idle();
    set_config(4, 2);
    push_item(ReqLoad, 0, 1'b0, DataMax, DataMax);
    push_item(ReqLoad, 0, 1'b1, DataMin, DataMin);
    push_item(ReqLoad, 1, 1'b0, 32768, 0);
    push_item(ReqLoad, 1, 1'b1, 0, 32768);
    push_item(ReqLoad, 2, 1'b0, 131071, -131072);
    push_item(ReqLoad, 2, 1'b1, -1, 1);
    push_detail(DataMax, DataMin);
    push_item(ReqUnused, '1, 1'b1, DataMax, DataMin);
    push_item(ReqApprox, 0, 1'b0, DataMax, DataMax);
    push_detail(DataMax, DataMin);
    push_detail(DataMin, DataMax);
    push_item(ReqApprox, '1, 1'b1, DataMin, DataMin);
    push_detail(DataMin, DataMin);
    push_detail(0, 0);
    wait_idle();
    set_config(4, 0);
    push_item(ReqApprox, 512, 1'b0, DataMax, DataMin);
    wait_idle();

    // The length changes in the middle of a bin; the level count stays latched.
    set_config(8, 3);
    push_item(ReqApprox, 5, 1'b0, rand_data(), rand_data());
    push_detail(rand_data(), rand_data());
    wait_idle();
    set_config(1024, 0);
    push_detail(rand_data(), rand_data());
    push_detail(rand_data(), rand_data());

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      case (p)
        0: begin len = 2; lv = 1; end
        1: begin len = 1024; lv = 8; end
        2: begin len = 0; lv = 0; end
        3: begin len = 2047; lv = 15; end
        4: begin len = 16; lv = 4; end
        5: begin len = 256; lv = 2; end
        6: begin len = $urandom_range(2, 1024); lv = $urandom_range(0, 8); end
        default: begin len = 64; lv = 3; end
      endcase
      set_config(len, lv);
      send_idle_en = (p != 7);
      recv_idle_en = (p != 7);
      if (p == 4) hold_requests++;
      run_phase(PhaseItems);
    end
    wait_idle();

    $display("Covered %0d input transfers and %0d checked bins over %0d register settings,",
             items_accepted, results_checked, n_settings);
    $display("including pass-through, clamped settings, a mid-bin change and a long stall.");
    if (recon_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin : sender
    swt_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap   <= 0;
    end else if (!(in_valid_i && !in_ready_o)) begin
      if (in_valid_i) items_accepted <= items_accepted + 1;
      if (send_gap != 0) begin
        send_gap   <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (send_idle_en && $urandom_range(0, 11) == 0) begin
        send_gap   <= $urandom_range(1, 18) - 1;
        in_valid_i <= 1'b0;
      end else if (swt_pending.size() != 0) begin
        nxt = swt_pending.pop_front();
        req_type_i   <= nxt.req;
        index_i      <= nxt.idx;
        filter_col_i <= nxt.col;
        value_re_i   <= nxt.re;
        value_im_i   <= nxt.im;
        in_valid_i   <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt    <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_cnt    <= LongHold;
      out_ready_i <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap    <= recv_gap - 1;
      out_ready_i <= 1'b0;
    end else if (recv_idle_en && $urandom_range(0, 11) == 0) begin
      recv_gap    <= $urandom_range(1, 18) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : monitor
    swt_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_checked <= results_checked + 1;
      if (recon_expected.size() == 0) begin
        $display("%0t: unexpected result, bin %0d re %0d im %0d", $time, bin_o,
                 out_re_o, out_im_o);
        recon_errors <= recon_errors + 1;
      end else begin
        want = recon_expected.pop_front();
        if (bin_o !== want.bin || out_re_o !== want.re || out_im_o !== want.im) begin
          $display("%0t: mismatch, expected bin %0d re %0d im %0d, got bin %0d re %0d im %0d",
                   $time, want.bin, want.re, want.im, bin_o, out_re_o, out_im_o);
          recon_errors <= recon_errors + 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog, no transfer for %0d cycles", $time, stall_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/fdis_pkg.sv
rtl/core/freq_domain_inverse_swt.sv
rtl/core/fdis_checker.sv
test/tb.sv
